/* rtl/rcfd_pkg.sv */
// Shared types and constants of the remote command frame decoder.
package rcfd_pkg;

	localparam int FRAME_LENGTH = 7;
	localparam int SCAN_LIMIT   = 8;
	localparam int CELLS        = FRAME_LENGTH - 1;
	localparam int POS_W        = 5;
	localparam logic [POS_W-1:0] POS_MAX   = '1;
	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(FRAME_LENGTH - 1);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LENGTH - 1 + SCAN_LIMIT);

	localparam logic [7:0] HEAD_MARK = 8'h5A;
	localparam logic [7:0] TAIL_MARK = 8'hA5;
	localparam logic [7:0] HOLD_BIT  = 8'h02;

	localparam logic signed [7:0] TRIM_LIMIT = 8'sd100;

	// message identifiers
	localparam logic [7:0] MSG_STICKS = 8'd1;
	localparam logic [7:0] MSG_STATUS = 8'd2;
	localparam logic [7:0] MSG_TRIM   = 8'd3;
	localparam logic [7:0] MSG_HOLD   = 8'd4;

	// sub-codes
	localparam logic [7:0] ATT_OFF         = 8'd0;
	localparam logic [7:0] ATT_ON          = 8'd1;
	localparam logic [7:0] TRIM_PITCH_DOWN = 8'd1;
	localparam logic [7:0] TRIM_PITCH_UP   = 8'd2;
	localparam logic [7:0] TRIM_ROLL_UP    = 8'd3;
	localparam logic [7:0] TRIM_ROLL_DOWN  = 8'd4;
	localparam logic [7:0] HOLD_RELEASE    = 8'd0;
	localparam logic [7:0] HOLD_ENGAGE     = 8'd1;

	typedef struct packed {
		logic [7:0]         rx_byte;
		logic               buffer_end;
		logic [15:0]        throttle_now;
		logic [15:0]        height_now_mm;
		logic signed [15:0] altitude_now;
	} link_item_t;

	typedef struct packed {
		logic               frame_ok;
		logic [7:0]         message_id;
		logic [31:0]        sticks;
		logic [7:0]         status_byte;
		logic               attitude_enable;
		logic signed [7:0]  pitch_trim;
		logic signed [7:0]  roll_trim;
		logic               hold_enable;
		logic [15:0]        hold_base_throttle;
		logic [15:0]        hold_target_height;
		logic signed [15:0] hold_target_altitude;
		logic               hold_pid_clear;
	} result_item_t;

	// window as seen after the current byte is shifted in
	typedef struct packed {
		logic [7:0] head;
		logic [7:0] id;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
		logic [7:0] p4;
		logic [7:0] tail;
	} frame_view_t;

endpackage

/* rtl/rcfd_link_if.sv */
// Input channel of the decoder: one received link byte and sensor values per item.
interface rcfd_link_if import rcfd_pkg::*; ();
	logic       valid;
	logic       ready;
	link_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/rcfd_result_if.sv */
// Output channel of the decoder: one result item per accepted byte.
interface rcfd_result_if import rcfd_pkg::*; ();
	logic         valid;
	logic         ready;
	result_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/rcfd_cell.sv */
// One byte cell of the receive window shift chain.
module rcfd_cell import rcfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

/* rtl/rcfd_cmd.sv */
// Frame acceptance, buffer tracking and command state of the decoder.
module rcfd_cmd import rcfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  link_item_t   item,
	input  frame_view_t  frame,
	output result_item_t res
);

	logic [POS_W-1:0]   pos_q, pos_n;
	logic               taken_q, taken_n;
	logic [31:0]        sticks_q, sticks_n;
	logic [7:0]         status_q, status_n;
	logic               att_q, att_n;
	logic signed [7:0]  pitch_q, pitch_n;
	logic signed [7:0]  roll_q, roll_n;
	logic               hold_q, hold_n;
	logic [15:0]        thr_q, thr_n;
	logic [15:0]        hgt_q, hgt_n;
	logic signed [15:0] alt_q, alt_n;
	logic               hit;
	logic               pid_clear;

	always_comb begin
		pos_n     = pos_q;
		taken_n   = taken_q;
		sticks_n  = sticks_q;
		status_n  = status_q;
		att_n     = att_q;
		pitch_n   = pitch_q;
		roll_n    = roll_q;
		hold_n    = hold_q;
		thr_n     = thr_q;
		hgt_n     = hgt_q;
		alt_n     = alt_q;
		pid_clear = 1'b0;

		hit = !taken_q && (pos_q >= POS_FIRST) && (pos_q < POS_LAST) &&
			(frame.head == HEAD_MARK) && (frame.tail == TAIL_MARK);

		if (hit) begin
			taken_n = 1'b1;
			case (frame.id)
				MSG_STICKS: begin
					sticks_n = {frame.p1, frame.p2, frame.p3, frame.p4};
				end
				MSG_STATUS: begin
					status_n = frame.p1;
					if (frame.p1 == ATT_ON) begin
						att_n = 1'b1;
					end else if (frame.p1 == ATT_OFF) begin
						att_n = 1'b0;
					end
				end
				MSG_TRIM: begin
					case (frame.p1)
						TRIM_PITCH_DOWN: begin
							if (pitch_q != -TRIM_LIMIT) pitch_n = pitch_q - 8'sd1;
						end
						TRIM_PITCH_UP: begin
							if (pitch_q != TRIM_LIMIT) pitch_n = pitch_q + 8'sd1;
						end
						TRIM_ROLL_UP: begin
							if (roll_q != TRIM_LIMIT) roll_n = roll_q + 8'sd1;
						end
						TRIM_ROLL_DOWN: begin
							if (roll_q != -TRIM_LIMIT) roll_n = roll_q - 8'sd1;
						end
						default: begin
						end
					endcase
				end
				MSG_HOLD: begin
					if (frame.p1 == HOLD_ENGAGE && !hold_q) begin
						hold_n   = 1'b1;
						status_n = status_q | HOLD_BIT;
						thr_n    = item.throttle_now;
						hgt_n    = item.height_now_mm;
						alt_n    = item.altitude_now;
					end else if (frame.p1 == HOLD_RELEASE && hold_q) begin
						hold_n    = 1'b0;
						status_n  = status_q & ~HOLD_BIT;
						thr_n     = '0;
						hgt_n     = '0;
						alt_n     = '0;
						pid_clear = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (pos_q != POS_MAX) pos_n = pos_q + POS_W'(1);

		// next buffer starts fresh
		if (item.buffer_end) begin
			pos_n   = '0;
			taken_n = 1'b0;
		end

		res.frame_ok             = hit;
		res.message_id           = hit ? frame.id : 8'd0;
		res.sticks               = sticks_n;
		res.status_byte          = status_n;
		res.attitude_enable      = att_n;
		res.pitch_trim           = pitch_n;
		res.roll_trim            = roll_n;
		res.hold_enable          = hold_n;
		res.hold_base_throttle   = thr_n;
		res.hold_target_height   = hgt_n;
		res.hold_target_altitude = alt_n;
		res.hold_pid_clear       = pid_clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			taken_q  <= 1'b0;
			sticks_q <= '0;
			status_q <= '0;
			att_q    <= 1'b0;
			pitch_q  <= '0;
			roll_q   <= '0;
			hold_q   <= 1'b0;
			thr_q    <= '0;
			hgt_q    <= '0;
			alt_q    <= '0;
		end else if (fire) begin
			pos_q    <= pos_n;
			taken_q  <= taken_n;
			sticks_q <= sticks_n;
			status_q <= status_n;
			att_q    <= att_n;
			pitch_q  <= pitch_n;
			roll_q   <= roll_n;
			hold_q   <= hold_n;
			thr_q    <= thr_n;
			hgt_q    <= hgt_n;
			alt_q    <= alt_n;
		end
	end

	a_taken_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		fire && hit && !item.buffer_end |=> taken_q)
		else $error("frame accepted but buffer not marked taken");

	a_buffer_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.buffer_end |=> pos_q == '0 && !taken_q)
		else $error("buffer end did not restart tracking");

	a_trim_range: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_q <= TRIM_LIMIT && pitch_q >= -TRIM_LIMIT &&
		roll_q <= TRIM_LIMIT && roll_q >= -TRIM_LIMIT)
		else $error("trim outside saturation range");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pid_clear |=> !hold_q && thr_q == '0 && hgt_q == '0 && alt_q == '0)
		else $error("hold release left latched state");

endmodule

/* rtl/remote_command_frame_decoder.sv */
// Top level of the remote command frame decoder: window cell chain and result register.
//
// Usage:
//   link   - sink channel; each item carries one received byte, a buffer_end
//            flag and the current throttle, height and altitude readings.
//   result - source channel; exactly one result item per accepted link item,
//            showing frame_ok/message_id for that byte and the command state
//            after it (sticks, status, trims, hold latches, PID clear pulse).
// The result of a byte is registered and appears in the cycle after it is accepted.
// Throughput: one byte per cycle while results are drained; the window is a chain
//   of six byte cells that shift together, and the decision uses the chain plus
//   the new byte in the same cycle, so nothing loops back across items.
// Stall: a single output register holds the pending result; link.ready stays
//   high while that register is empty or being drained, so a new byte is
//   taken in the same cycle the old result leaves.
// Reset: arst_n clears the window, buffer position, taken flag, all command
//   state and the output valid; link.ready is high coming out of reset.
// A byte flagged buffer_end is decoded normally, then the window, position
//   and taken flag are cleared for the next buffer.
module remote_command_frame_decoder import rcfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rcfd_link_if.sink     link,
	rcfd_result_if.source result
);

	logic         fire;
	logic         out_valid_q;
	result_item_t res_q;
	result_item_t res_next;
	logic [7:0]   cell_d [CELLS];
	logic [7:0]   cell_q [CELLS];
	frame_view_t  frame;

	// input side keeps moving while the result slot is empty or frees this cycle
	assign link.ready = !out_valid_q || result.ready;
	assign fire       = link.valid && link.ready;

	// cell k takes its right neighbor; the last cell takes the new byte
	genvar k;
	generate
		for (k = 0; k < CELLS; k++) begin : g_cell
			if (k == CELLS - 1) begin : g_tail
				assign cell_d[k] = link.data.rx_byte;
			end else begin : g_body
				assign cell_d[k] = cell_q[k+1];
			end

			rcfd_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (fire),
				.clear  (fire && link.data.buffer_end),
				.d      (cell_d[k]),
				.q      (cell_q[k])
			);
		end
	endgenerate

	// window after this byte: oldest cell becomes the head, new byte the tail
	assign frame.head = cell_q[0];
	assign frame.id   = cell_q[1];
	assign frame.p1   = cell_q[2];
	assign frame.p2   = cell_q[3];
	assign frame.p3   = cell_q[4];
	assign frame.p4   = cell_q[5];
	assign frame.tail = link.data.rx_byte;

	rcfd_cmd u_cmd (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (link.data),
		.frame  (frame),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

endmodule
